>>> hw/rtl/isax_split_segment_by_next_bit_top_macros.svh
// Assertion macros used by the split-segment selector checker.
`ifndef ISAX_SPLIT_SEGMENT_BY_NEXT_BIT_TOP_MACROS_SVH
`define ISAX_SPLIT_SEGMENT_BY_NEXT_BIT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ISAXSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ISAXSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/isaxss_pkg.sv
// Types and constants of the iSAX split-segment selector.
package isaxss_pkg;

    // Parameter defaults
    localparam int MAX_SEGMENTS_DEF    = 16;
    localparam int MAX_LEAF_SERIES_DEF = 1024;
    localparam int SYMBOL_BITS_DEF     = 8;

    // Fixed field widths
    localparam int SEG_W   = 4;
    localparam int VALUE_W = 8;
    localparam int CNT_W   = 12;
    localparam int ABS_W   = 11;
    localparam int CFG_W   = 5;

    // Largest balance magnitude a counter may hold
    localparam int BAL_CAP = 2047;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Request modes
    localparam logic MODE_MASK   = 1'b0;
    localparam logic MODE_SYMBOL = 1'b1;

    // Mask value that marks a segment at full cardinality
    localparam logic [VALUE_W-1:0] MASK_FULL = 8'd1;

    typedef struct packed {
        logic               mode;
        logic [SEG_W-1:0]   segment;
        logic [VALUE_W-1:0] value;
        logic               last;
    } sym_req_t;

    typedef struct packed {
        logic [SEG_W-1:0] split_segment;
        logic             found;
        logic [ABS_W-1:0] best_balance;
    } res_req_t;

endpackage

>>> hw/rtl/isaxss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module isaxss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/isax_split_segment_by_next_bit_top.sv
// iSAX split-segment selector: per-segment next-bit balance and split choice.
// Mask loads and symbols are taken one per cycle while sym_ready is high (low in the walk and
// result hand-off); a symbol updates its counter in the next cycle. After the last symbol
// the walk reads limit = min(segments_in_use, MAX_SEGMENTS) segments, one a cycle.
// Reset: counters read as zero (per-entry valid flops), segments_in_use = 16, masks undefined.
module isax_split_segment_by_next_bit_top
    import isaxss_pkg::*;
#(
    parameter int MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
    parameter int MAX_LEAF_SERIES = MAX_LEAF_SERIES_DEF,
    parameter int SYMBOL_BITS     = SYMBOL_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             sym_valid,
    output logic             sym_ready,
    input  sym_req_t         sym_req,
    output logic             res_valid,
    input  logic             res_ready,
    output res_req_t         res_req
);

    localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int LW  = ($clog2(MAX_SEGMENTS + 1) > CFG_W) ? $clog2(MAX_SEGMENTS + 1) : CFG_W;
    localparam int LIM = (MAX_LEAF_SERIES < BAL_CAP) ? MAX_LEAF_SERIES : BAL_CAP;
    localparam logic signed [CNT_W-1:0] BAL_POS = CNT_W'(LIM);
    localparam logic signed [CNT_W-1:0] BAL_NEG = -CNT_W'(LIM);
    localparam logic [VALUE_W-1:0] SYM_MASK =
        (SYMBOL_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((1 << SYMBOL_BITS) - 1);
    localparam logic [LW-1:0] SEG_MAX = LW'(MAX_SEGMENTS);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CFG_W-1:0]       seg_use_reg;

    // Symbol update stage
    logic                   s1_valid_reg, s1_last_reg, s1_ok_reg;
    logic [AW-1:0]          s1_addr_reg;
    logic [VALUE_W-1:0]     s1_val_reg;

    // Forwarding of the counter written in the previous cycle
    logic                   fwd_valid_reg;
    logic [AW-1:0]          fwd_addr_reg;
    logic signed [CNT_W-1:0] fwd_cnt_reg;

    logic [MAX_SEGMENTS-1:0] cnt_vld_reg, cnt_vld_next;

    // Walk state
    logic [LW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   p_valid_reg;
    logic [LW-1:0]          p_idx_reg;
    logic                   found_reg, found_next;
    logic [LW-1:0]          best_idx_reg, best_idx_next;
    logic [ABS_W-1:0]       best_abs_reg, best_abs_next;
    logic [VALUE_W-1:0]     best_mask_reg, best_mask_next;

    logic                   res_valid_reg, res_valid_next;
    res_req_t               res_req_reg;

    logic                   sym_acc, is_sym, seg_ok, walk_issue, done_load;
    logic [LW-1:0]          seg_ext, limit;
    logic [AW-1:0]          seg_addr, rd_addr;
    logic                   mask_we, rd_en, cnt_we;
    logic [VALUE_W-1:0]     mask_rdata;
    logic [CNT_W-1:0]       cnt_rdata;
    logic signed [CNT_W-1:0] cnt_old, cnt_new, w_cnt, w_abs_s;
    logic                   hit, eligible;
    logic [ABS_W-1:0]       w_abs;

    // Input decode
    assign sym_ready = (state_reg == ST_RUN) && !(s1_valid_reg && s1_last_reg);
    assign sym_acc   = sym_valid && sym_ready;
    assign is_sym    = (sym_req.mode == MODE_SYMBOL);
    assign seg_ext   = {{(LW - SEG_W){1'b0}}, sym_req.segment};
    assign seg_ok    = (seg_ext < SEG_MAX);
    assign seg_addr  = seg_ext[AW-1:0];

    assign limit = (LW'(seg_use_reg) < SEG_MAX) ? LW'(seg_use_reg) : SEG_MAX;

    assign walk_issue = (state_reg == ST_WALK) && (rd_idx_reg < limit);

    // Memory port control
    assign mask_we = sym_acc && !is_sym && seg_ok;
    assign rd_en   = (sym_acc && is_sym) || walk_issue;
    assign rd_addr = (state_reg == ST_WALK) ? rd_idx_reg[AW-1:0] : seg_addr;
    assign cnt_we  = s1_valid_reg && s1_ok_reg;

    isaxss_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (seg_addr),
        .wdata (sym_req.value & SYM_MASK),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (mask_rdata)
    );

    isaxss_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (s1_addr_reg),
        .wdata (cnt_new),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (cnt_rdata)
    );

    // Counter update with forwarding and saturation
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cnt_old = fwd_cnt_reg;
        end
        else if (cnt_vld_reg[s1_addr_reg])
        begin
            cnt_old = cnt_rdata;
        end
        else
        begin
            cnt_old = '0;
        end
        hit = |(s1_val_reg & (mask_rdata >> 1));
        if (hit)
        begin
            cnt_new = (cnt_old < BAL_POS) ? cnt_old + CNT_W'(1) : cnt_old;
        end
        else
        begin
            cnt_new = (cnt_old > BAL_NEG) ? cnt_old - CNT_W'(1) : cnt_old;
        end
    end

    // Walk evaluation of one segment
    always_comb
    begin
        w_cnt    = cnt_vld_reg[p_idx_reg[AW-1:0]] ? cnt_rdata : '0;
        w_abs_s  = (w_cnt < 0) ? -w_cnt : w_cnt;
        w_abs    = w_abs_s[ABS_W-1:0];
        eligible = (mask_rdata != MASK_FULL);

        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_abs_next  = best_abs_reg;
        best_mask_next = best_mask_reg;
        if (state_reg == ST_RUN)
        begin
            found_next     = 1'b0;
            best_idx_next  = '0;
            best_abs_next  = '0;
            best_mask_next = '0;
        end
        else if (p_valid_reg && eligible)
        begin
            if (!found_reg || (w_abs < best_abs_reg))
            begin
                found_next     = 1'b1;
                best_idx_next  = p_idx_reg;
                best_abs_next  = w_abs;
                best_mask_next = mask_rdata;
            end
            else if ((w_abs == best_abs_reg) && (mask_rdata > best_mask_reg))
            begin
                best_idx_next  = p_idx_reg;
                best_mask_next = mask_rdata;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        done_load   = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                rd_idx_next = '0;
                if (s1_valid_reg && s1_last_reg)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_issue)
                begin
                    rd_idx_next = rd_idx_reg + LW'(1);
                end
                else if (!p_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    done_load  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Counter valid flags: set on write, cleared after each walk
    always_comb
    begin
        cnt_vld_next = cnt_vld_reg;
        if (cnt_we)
        begin
            cnt_vld_next[s1_addr_reg] = 1'b1;
        end
        if (done_load)
        begin
            cnt_vld_next = '0;
        end
    end

    assign res_valid_next = done_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            seg_use_reg   <= CFG_RESET;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            cnt_vld_reg   <= '0;
            p_valid_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                seg_use_reg <= cfg_wdata;
            end
            s1_valid_reg  <= sym_acc && is_sym;
            fwd_valid_reg <= cnt_we;
            cnt_vld_reg   <= cnt_vld_next;
            p_valid_reg   <= walk_issue;
            rd_idx_reg    <= rd_idx_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (sym_acc && is_sym)
        begin
            s1_last_reg <= sym_req.last;
            s1_ok_reg   <= seg_ok;
            s1_addr_reg <= seg_addr;
            s1_val_reg  <= sym_req.value & SYM_MASK;
        end
        if (cnt_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_cnt_reg  <= cnt_new;
        end
        p_idx_reg     <= rd_idx_reg;
        best_idx_reg  <= best_idx_next;
        best_abs_reg  <= best_abs_next;
        best_mask_reg <= best_mask_next;
        if (done_load)
        begin
            res_req_reg.split_segment <= best_idx_reg[SEG_W-1:0];
            res_req_reg.found         <= found_reg;
            res_req_reg.best_balance  <= best_abs_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_req   = res_req_reg;

endmodule

>>> hw/rtl/isaxss_checker.sv
// Port-level checker for the split-segment selector, bound to the top level.
`include "isax_split_segment_by_next_bit_top_macros.svh"

module isaxss_checker
    import isaxss_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     sym_valid,
    input logic     sym_ready,
    input sym_req_t sym_req,
    input logic     res_valid,
    input logic     res_ready,
    input res_req_t res_req
);

    // A stalled result request holds
    `ISAXSS_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_req), "result request changed while stalled")

    // No segment found means zero segment and balance
    `ISAXSS_ASSERT_IMP(a_not_found_zero, clk, rst_n, res_valid && !res_req.found, (res_req.split_segment == '0) && (res_req.best_balance == '0), "nonzero result without a found segment")

    // The walk blocks new requests right after the last symbol
    `ISAXSS_ASSERT_NXT(a_last_blocks, clk, rst_n, sym_valid && sym_ready && (sym_req.mode == MODE_SYMBOL) && sym_req.last, !sym_ready, "request taken while the walk starts")

    // A new result only appears while input is blocked
    `ISAXSS_ASSERT_IMP(a_result_busy, clk, rst_n, $rose(res_valid), !$past(sym_ready), "result appeared without a walk")

endmodule

bind isax_split_segment_by_next_bit_top isaxss_checker u_isaxss_checker (.*);
